// File: sv/mqsb_pkg.sv
// mqsb_pkg: shared types, codes and helpers of the multi-queue shared buffer.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package mqsb_pkg;

    // Fixed field widths of the item and result
    localparam int unsigned DATA_W = 32;
    localparam int unsigned QID_W  = 2;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_NUM_SLOTS  = 16;
    localparam int unsigned DEF_NUM_QUEUES = 4;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                     cmd;
        logic [QID_W-1:0]         queue_id;
        logic signed [DATA_W-1:0] data_in;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data_out;
        logic                     queue_now_empty;
        logic                     store_now_full;
    } t_out_item;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_POP,
        S_LINK
    } t_state;

    // Controller to datapath, at most one set per cycle
    typedef struct packed {
        logic capture;     // take the item, launch queue and free-link reads
        logic reject;      // error result, no state change
        logic enq_commit;  // allocate free slot, store item, update queue
        logic deq_read;    // read link and data of the queue head slot
        logic deq_commit;  // unlink head, push slot on free list
        logic tail_link;   // link old tail to the new slot
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_deq;
        logic free_null;
        logic q_nonempty;
    } t_dp_sts;

    // Queue number wraps modulo the queue count (few compare/subtract steps)
    function automatic logic [QID_W-1:0] f_wrap_qid(input logic [QID_W-1:0] qid,
                                                    input int unsigned     nq);
        logic [QID_W-1:0] v;
        v = qid;
        for (int i = 0; i < (1 << QID_W) - 1; i++) begin
            if (32'(v) >= nq) begin
                v = v - QID_W'(nq);
            end
        end
        return v;
    endfunction

endpackage

// File: sv/mqsb_ram.sv
// mqsb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mqsb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mqsb_ctrl.sv
// mqsb_ctrl: operation sequencer of the multi-queue shared buffer.
// Depends on mqsb_pkg; drives the datapath mqsb_dp through t_dp_cmd.
`timescale 1ns / 1ps

module mqsb_ctrl
    import mqsb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.is_deq) begin
                    if (!i_sts.q_nonempty) begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.deq_read = 1'b1;
                        n_state        = S_POP;
                    end
                end else begin
                    if (i_sts.free_null) begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.enq_commit = 1'b1;
                        // a non-empty queue still needs its old tail linked
                        n_state = i_sts.q_nonempty ? S_LINK : S_IDLE;
                    end
                end
            end
            S_POP: begin
                o_cmd.deq_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_LINK: begin
                o_cmd.tail_link = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: sv/mqsb_dp.sv
// mqsb_dp: pointer registers, slot/link/queue memories and result register.
// Depends on mqsb_pkg and mqsb_ram; sequenced by mqsb_ctrl.
`timescale 1ns / 1ps

module mqsb_dp
    import mqsb_pkg::*;
#(
    parameter int unsigned NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int unsigned NUM_QUEUES = DEF_NUM_QUEUES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_done,
    output t_out_item o_result
);

    localparam int unsigned SW = $clog2(NUM_SLOTS);
    localparam int unsigned PW = $clog2(NUM_SLOTS + 1);
    localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

    // Captured item
    t_cmd              r_cmd;
    logic [QW-1:0]     r_q;
    logic [DATA_W-1:0] r_data;

    // Pointer state
    logic [PW-1:0]         r_free_head;
    logic [PW-1:0]         r_fill;       // slots below this were ever allocated
    logic [SW-1:0]         r_slot;
    logic [SW-1:0]         r_link_raddr;
    logic [NUM_QUEUES-1:0] r_q_ne;       // per-queue non-empty flag

    // Result register
    logic      r_done;
    t_out_item r_res;
    t_out_item n_res;
    logic      emit;

    // Memory ports
    logic              q_we, q_re;
    logic [QW-1:0]     q_raddr;
    logic [2*SW-1:0]   q_wdata, q_rdata;
    logic              link_we, link_re;
    logic [SW-1:0]     link_waddr, link_raddr;
    logic [PW-1:0]     link_wdata, link_rdata;
    logic              data_we, data_re;
    logic [DATA_W-1:0] data_rdata;

    logic [SW-1:0] head, tail, s;
    logic [PW-1:0] link_adj;
    logic          adj_null, free_null, q_ne_cur;

    assign head      = q_rdata[2*SW-1:SW];
    assign tail      = q_rdata[SW-1:0];
    assign s         = r_free_head[SW-1:0];
    assign free_null = (r_free_head >= NULL_PTR);
    assign q_ne_cur  = r_q_ne[r_q];

    // A slot never allocated reads as linked to the next slot, its reset link
    assign link_adj = (PW'(r_link_raddr) < r_fill) ? link_rdata
                                                   : PW'(r_link_raddr) + PW'(1);
    assign adj_null = (link_adj >= NULL_PTR);

    assign o_sts.is_deq     = (r_cmd == CMD_DEQ);
    assign o_sts.free_null  = free_null;
    assign o_sts.q_nonempty = q_ne_cur;

    // Queue memory: {head, tail} per queue
    assign q_re    = i_cmd.capture;
    assign q_raddr = QW'(f_wrap_qid(i_item.queue_id, NUM_QUEUES));
    assign q_we    = i_cmd.enq_commit | i_cmd.deq_commit;
    assign q_wdata = i_cmd.enq_commit ? {(q_ne_cur ? head : s), s}
                                      : {link_adj[SW-1:0], tail};

    // Link memory addressing
    assign link_re    = i_cmd.capture | i_cmd.deq_read;
    assign link_raddr = i_cmd.deq_read ? head : s;
    assign link_we    = i_cmd.enq_commit | i_cmd.tail_link | i_cmd.deq_commit;
    always_comb begin
        if (i_cmd.enq_commit) begin
            link_waddr = s;
            link_wdata = NULL_PTR;
        end else if (i_cmd.tail_link) begin
            link_waddr = tail;
            link_wdata = PW'(r_slot);
        end else begin
            link_waddr = r_slot;
            link_wdata = r_free_head;
        end
    end

    // Slot data memory
    assign data_we = i_cmd.enq_commit;
    assign data_re = i_cmd.deq_read;

    mqsb_ram #(.WIDTH(2 * SW), .DEPTH(NUM_QUEUES), .AW(QW)) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_q),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    mqsb_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS), .AW(SW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    mqsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS), .AW(SW)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (s),
        .i_wdata (r_data),
        .i_re    (data_re),
        .i_raddr (head),
        .o_rdata (data_rdata)
    );

    // Control state: free list, fill count, queue flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fill      <= '0;
            r_q_ne      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= emit;
            if (i_cmd.enq_commit) begin
                r_free_head <= link_adj;
                r_q_ne[r_q] <= 1'b1;
                if (PW'(s) >= r_fill) begin
                    r_fill <= r_fill + PW'(1);
                end
            end
            if (i_cmd.deq_commit) begin
                r_free_head <= PW'(r_slot);
                r_q_ne[r_q] <= !adj_null;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_item.cmd;
            r_q    <= q_raddr;
            r_data <= i_item.data_in;
        end
        if (link_re) begin
            r_link_raddr <= link_raddr;
        end
        if (i_cmd.enq_commit) begin
            r_slot <= s;
        end
        if (i_cmd.deq_read) begin
            r_slot <= head;
        end
        if (emit) begin
            r_res <= n_res;
        end
    end

    // Result formation
    always_comb begin
        emit                  = 1'b0;
        n_res.status          = ST_OK;
        n_res.data_out        = '0;
        n_res.queue_now_empty = 1'b0;
        n_res.store_now_full  = free_null;
        if (i_cmd.reject) begin
            emit                  = 1'b1;
            n_res.status          = (r_cmd == CMD_DEQ) ? ST_EMPTY : ST_FULL;
            n_res.queue_now_empty = !q_ne_cur;
        end
        if (i_cmd.enq_commit && !q_ne_cur) begin
            emit                 = 1'b1;
            n_res.store_now_full = adj_null;
        end
        if (i_cmd.tail_link) begin
            emit = 1'b1;
        end
        if (i_cmd.deq_commit) begin
            emit                  = 1'b1;
            n_res.data_out        = data_rdata;
            n_res.queue_now_empty = adj_null;
            n_res.store_now_full  = 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // Fill count never passes the slot count
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NULL_PTR)
        else $error("fill count beyond slot count");

    // A full-store reject always reports the store as full
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> o_result.store_now_full)
        else $error("full status without full flag");

    // An empty-queue reject always reports the queue as empty
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> o_result.queue_now_empty)
        else $error("empty status without empty flag");

    // Rejected operations return zero data
    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.data_out == '0))
        else $error("error result with nonzero data");

    // The free head is either a valid slot or null
    a_free_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= NULL_PTR)
        else $error("free head pointer out of range");
`endif

endmodule

// File: sv/multi_queue_shared_buffer_unit.sv
// multi_queue_shared_buffer_unit: top level of the multi-queue shared buffer.
// Depends on mqsb_pkg, mqsb_ctrl, mqsb_dp (and mqsb_ram through mqsb_dp).
`timescale 1ns / 1ps
//
// NUM_QUEUES FIFO queues share one store of NUM_SLOTS slots, kept as linked
// lists with a free list of unused slots.
// Input: an item (cmd, queue_id, data_in) is taken when start is high and
// busy is low. busy stays high while the item is being worked on.
// Output: one result per item, shown on o_result for exactly one cycle with
// o_done high. The receiver cannot stall it; the next item may already be
// started while that result is shown.
// Sequence: an enqueue into an empty queue, or a rejected one, ends after
// the queue and free-link reads; into a non-empty queue it adds a second
// write to the link memory. A dequeue ends there when rejected, else its
// head read is followed by a link and data read. The result is shown in
// the first cycle with busy low. Registered memory reads set the extra
// dequeue step; the single write port of the link memory, the enqueue one.
// Reset: synchronous, active low. All queues are empty and every slot is
// free right after reset; no clearing pass is needed, since a fill count
// supplies the reset links of slots that were never allocated.

module multi_queue_shared_buffer_unit
    import mqsb_pkg::*;
#(
    parameter int unsigned NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int unsigned NUM_QUEUES = DEF_NUM_QUEUES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    mqsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // Pointers, memories and result register
    mqsb_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_sts    (dp_sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
